/* rtl/lli_pkg.sv */
// shared constants and types for the two-line intersection block
package lli_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

endpackage

/* rtl/line_line_intersection.sv */
// top level of the two-line intersection block
// throughput: one line pair per cycle unless out_tready stalls the output
// the division gives one quotient bit per stage after a first range-check stage
// a four-entry queue decouples the front products from the back divider pipeline
// reset: synchronous active-low rst_n empties the pipelines and the queue
module line_line_intersection #(
  parameter int COORD_WIDTH = lli_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // first_point_x, first_point_y, first_dir_x, first_dir_y,
  // second_point_x, second_point_y, second_dir_x, second_dir_y
  input  logic [8*COORD_WIDTH-1:0]              in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // cross_x, cross_y, zero padding
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    out_tdata,
  // status
  output lli_pkg::status_t                      out_tuser
);
  import lli_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int QW = 4 * W + 2 * (2 * W + 1) + 2;
  localparam int OW = ((2 * W + 7) / 8) * 8;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0] f_data, b_data;

  lli_front #(.COORD_WIDTH(W), .QW(QW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_data    (f_data)
  );

  lli_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  lli_back #(.COORD_WIDTH(W), .QW(QW), .OW(OW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_data     (b_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/lli_front.sv */
// front end: cross products, determinant and zero-determinant classification
module lli_front #(
  parameter int COORD_WIDTH = lli_pkg::COORD_WIDTH_DEF,
  parameter int QW          = 4 * COORD_WIDTH + 2 * (2 * COORD_WIDTH + 1) + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [8*COORD_WIDTH-1:0] in_tdata,
  output logic                     q_valid,
  input  logic                     q_ready,
  output logic [QW-1:0]            q_data
);
  import lli_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2 * W + 1;

  logic signed [W-1:0] p1x, p1y, d1x, d1y, p2x, p2y, d2x, d2y;
  logic signed [W:0]   dpx, dpy;
  logic                en;

  logic                f1_vld_r;
  logic signed [DW-1:0] m_a_r, m_b_r, m_c_r, m_d_r;
  logic signed [W-1:0] f1_p1x_r, f1_p1y_r, f1_d1x_r, f1_d1y_r;

  logic signed [DW:0]  den, num;
  logic [DW:0]         den_abs, num_abs;

  logic                f2_vld_r;
  logic [QW-1:0]       f2_data_r;

  assign p1x = $signed(in_tdata[0*W +: W]);
  assign p1y = $signed(in_tdata[1*W +: W]);
  assign d1x = $signed(in_tdata[2*W +: W]);
  assign d1y = $signed(in_tdata[3*W +: W]);
  assign p2x = $signed(in_tdata[4*W +: W]);
  assign p2y = $signed(in_tdata[5*W +: W]);
  assign d2x = $signed(in_tdata[6*W +: W]);
  assign d2y = $signed(in_tdata[7*W +: W]);

  assign dpx = $signed({p2x[W-1], p2x}) - $signed({p1x[W-1], p1x});
  assign dpy = $signed({p2y[W-1], p2y}) - $signed({p1y[W-1], p1y});

  assign en        = !f2_vld_r || q_ready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_tvalid;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_a_r    <= d1x * d2y;
      m_b_r    <= d1y * d2x;
      m_c_r    <= dpx * d2y;
      m_d_r    <= dpy * d2x;
      f1_p1x_r <= p1x;
      f1_p1y_r <= p1y;
      f1_d1x_r <= d1x;
      f1_d1y_r <= d1y;
    end
  end

  assign den     = $signed({m_a_r[DW-1], m_a_r}) - $signed({m_b_r[DW-1], m_b_r});
  assign num     = $signed({m_c_r[DW-1], m_c_r}) - $signed({m_d_r[DW-1], m_d_r});
  assign den_abs = den[DW] ? -den : den;
  assign num_abs = num[DW] ? -num : num;

  // word: zero flag, p1x, p1y, d1x, d1y, quotient sign, |num|, |den|
  always_ff @(posedge clk) begin
    if (en) begin
      f2_data_r <= {(den == '0), f1_p1x_r, f1_p1y_r, f1_d1x_r, f1_d1y_r,
                    num[DW] ^ den[DW], num_abs[DW-1:0], den_abs[DW-1:0]};
    end
  end

  assign q_valid = f2_vld_r;
  assign q_data  = f2_data_r;

endmodule

/* rtl/lli_queue.sv */
// small first-word-fall-through queue between front and back
module lli_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lli_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  import lli_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

endmodule

/* rtl/lli_back.sv */
// back end: scaled products, pipelined restoring division and saturation
module lli_back #(
  parameter int COORD_WIDTH = lli_pkg::COORD_WIDTH_DEF,
  parameter int QW          = 4 * COORD_WIDTH + 2 * (2 * COORD_WIDTH + 1) + 2,
  parameter int OW          = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  logic [QW-1:0]           q_data,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OW-1:0]           out_tdata,
  output lli_pkg::status_t        out_tuser
);
  import lli_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = 2 * W + 1;
  localparam int LW   = 3 * W + 1;
  localparam int NDIV = W + 2;

  logic en;

  // unpacked queue word
  logic          u_z, u_neg;
  logic [W-1:0]  u_base [2];
  logic [W-1:0]  u_dir  [2];
  logic [W-1:0]  u_dmag [2];
  logic [DW-1:0] u_num, u_den;

  assign {u_z, u_base[0], u_base[1], u_dir[0], u_dir[1], u_neg, u_num, u_den} = q_data;

  assign en      = !out_tvalid || out_tready;
  assign q_ready = en;

  // partial product stage
  logic          p_vld_r, p_z_r;
  logic [2*W-1:0] p_lo_r [2];
  logic [2*W:0]  p_hi_r [2];
  logic [DW-1:0] p_den_r;
  logic [W-1:0]  p_base_r [2];
  logic          p_neg_r [2];

  // sum stage
  logic          s_vld_r, s_z_r;
  logic [LW-1:0] s_dvd_r [2];
  logic [DW-1:0] s_den_r;
  logic [W-1:0]  s_base_r [2];
  logic          s_neg_r [2];

  // division stages, one quotient bit each, the first only checks the range
  logic [NDIV-1:0] dv_vld_r;
  logic            dv_z_r    [NDIV];
  logic [DW-1:0]   dv_den_r  [NDIV];
  logic [LW-1:0]   dv_rem_r  [NDIV][2];
  logic [W:0]      dv_q_r    [NDIV][2];
  logic            dv_ovf_r  [NDIV][2];
  logic [W-1:0]    dv_base_r [NDIV][2];
  logic            dv_neg_r  [NDIV][2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      u_dmag[l] = u_dir[l][W-1] ? (~u_dir[l] + 1'b1) : u_dir[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r  <= 1'b0;
      s_vld_r  <= 1'b0;
    end else if (en) begin
      p_vld_r  <= q_valid;
      s_vld_r  <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_z_r   <= u_z;
      p_den_r <= u_den;
      s_z_r   <= p_z_r;
      s_den_r <= p_den_r;
      for (int l = 0; l < 2; l++) begin
        p_lo_r[l]   <= u_num[W-1:0] * u_dmag[l];
        p_hi_r[l]   <= u_num[DW-1:W] * u_dmag[l];
        p_base_r[l] <= u_base[l];
        p_neg_r[l]  <= u_neg ^ u_dir[l][W-1];
        s_dvd_r[l]  <= {p_hi_r[l], {W{1'b0}}} + {{(W+1){1'b0}}, p_lo_r[l]};
        s_base_r[l] <= p_base_r[l];
        s_neg_r[l]  <= p_neg_r[l];
      end
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int SH = W + 1 - k;

    logic          prv_vld, prv_z;
    logic [DW-1:0] prv_den;
    logic [LW-1:0] prv_rem  [2];
    logic [W:0]    prv_q    [2];
    logic          prv_ovf  [2];
    logic [W-1:0]  prv_base [2];
    logic          prv_neg  [2];
    logic [LW:0]   cand;
    logic          ge       [2];

    if (k == 0) begin : g_first
      assign prv_vld = s_vld_r;
      assign prv_z   = s_z_r;
      assign prv_den = s_den_r;
      for (genvar l = 0; l < 2; l++) begin : g_l
        assign prv_rem[l]  = s_dvd_r[l];
        assign prv_q[l]    = '0;
        assign prv_ovf[l]  = 1'b0;
        assign prv_base[l] = s_base_r[l];
        assign prv_neg[l]  = s_neg_r[l];
      end
    end else begin : g_next
      assign prv_vld = dv_vld_r[k-1];
      assign prv_z   = dv_z_r[k-1];
      assign prv_den = dv_den_r[k-1];
      for (genvar l = 0; l < 2; l++) begin : g_l
        assign prv_rem[l]  = dv_rem_r[k-1][l];
        assign prv_q[l]    = dv_q_r[k-1][l];
        assign prv_ovf[l]  = dv_ovf_r[k-1][l];
        assign prv_base[l] = dv_base_r[k-1][l];
        assign prv_neg[l]  = dv_neg_r[k-1][l];
      end
    end

    assign cand = {{(LW+1-DW){1'b0}}, prv_den} << SH;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        ge[l] = {1'b0, prv_rem[l]} >= cand;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (en) begin
        dv_vld_r[k] <= prv_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_z_r[k]   <= prv_z;
        dv_den_r[k] <= prv_den;
        for (int l = 0; l < 2; l++) begin
          dv_base_r[k][l] <= prv_base[l];
          dv_neg_r[k][l]  <= prv_neg[l];
          if (k == 0) begin
            // quotient would not fit in W+1 bits: saturates whatever the base
            dv_ovf_r[k][l] <= ge[l];
            dv_rem_r[k][l] <= prv_rem[l];
            dv_q_r[k][l]   <= '0;
          end else begin
            dv_ovf_r[k][l] <= prv_ovf[l];
            dv_q_r[k][l]   <= {prv_q[l][W-1:0], ge[l]};
            dv_rem_r[k][l] <= ge[l] ? (prv_rem[l] - cand[LW-1:0]) : prv_rem[l];
          end
        end
      end
    end
  end

  // saturation and output register
  logic [W+2:0]  v      [2];
  logic [W-1:0]  coord  [2];
  logic          sat    [2];
  logic          out_vld_r;
  logic [W-1:0]  out_x_r, out_y_r;
  status_t       out_st_r, st_nxt;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      // base plus or minus a quotient below 2^(W+1) needs W+3 bits
      if (dv_neg_r[NDIV-1][l])
        v[l] = {{3{dv_base_r[NDIV-1][l][W-1]}}, dv_base_r[NDIV-1][l]}
               - {2'b00, dv_q_r[NDIV-1][l]};
      else
        v[l] = {{3{dv_base_r[NDIV-1][l][W-1]}}, dv_base_r[NDIV-1][l]}
               + {2'b00, dv_q_r[NDIV-1][l]};
      if (dv_ovf_r[NDIV-1][l]) begin
        sat[l]   = 1'b1;
        coord[l] = dv_neg_r[NDIV-1][l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else if ((v[l][W+2:W-1] != 4'b0000) && (v[l][W+2:W-1] != 4'b1111)) begin
        sat[l]   = 1'b1;
        coord[l] = v[l][W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        sat[l]   = 1'b0;
        coord[l] = v[l][W-1:0];
      end
    end
    if (dv_z_r[NDIV-1])      st_nxt = ST_NONE;
    else if (sat[0] || sat[1]) st_nxt = ST_SAT;
    else                     st_nxt = ST_FOUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[NDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r <= st_nxt;
      out_x_r  <= dv_z_r[NDIV-1] ? '0 : coord[0];
      out_y_r  <= dv_z_r[NDIV-1] ? '0 : coord[1];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {{(OW-2*W){1'b0}}, out_y_r, out_x_r};

endmodule
